[design/mcl_pkg.sv]
// Shared types and constants for the controller learn mapper.
// Used by mcl_cell, mcl_match and midi_cc_learn_mapper; depends on nothing.
package mcl_pkg;

  localparam int LAYERS  = 4;
  localparam int TARGETS = 5;
  localparam int SLOTS   = LAYERS * TARGETS;
  localparam int SLOT_W  = $clog2(SLOTS);
  // layer counters and bounds hold values up to LAYERS inclusive
  localparam int LCW     = 4;

  localparam logic [6:0] SUSTAIN_CC = 7'd64;
  localparam logic [6:0] VALUE_MAX  = 7'd127;
  localparam logic [4:0] ANY_CHANNEL = 5'd0;

  typedef enum logic {
    OP_MIDI = 1'b0,
    OP_ARM  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic       opcode;
    logic       is_controller;
    logic [6:0] cc_number;
    logic [4:0] channel;
    logic [6:0] cc_value;
    logic       filter_enable;
    logic [2:0] layer;
    logic [2:0] target;
  } in_t;

  typedef struct packed {
    logic [1:0] upd_layer;
    logic [2:0] upd_target;
    logic [6:0] upd_value;
    logic       last;
  } out_t;

  // one learned mapping: unlearned flag, controller number, channel (0 = any)
  typedef struct packed {
    logic       unlearned;
    logic [6:0] cc;
    logic [4:0] chan;
  } entry_t;

  // message held for the duration of a scan
  typedef struct packed {
    logic [6:0] cc;
    logic [4:0] chan;
    logic [6:0] val;
    logic       binary;
  } msg_t;

  localparam entry_t ENTRY_RESET = '{unlearned: 1'b1, cc: 7'd0, chan: ANY_CHANNEL};

endpackage

[design/mcl_cell.sv]
// One storage cell of the mapping ring: holds a single learned entry.
// Depends on mcl_pkg for the entry type and its reset value.
module mcl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  mcl_pkg::entry_t    entry_i,
  output mcl_pkg::entry_t    entry_o
);

  mcl_pkg::entry_t entry_q;

  // take the neighbour's entry on every scan step, hold otherwise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= mcl_pkg::ENTRY_RESET;
    end else if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

[design/mcl_match.sv]
// Head of the mapping ring: applies a pending capture and tests the entry
// against the current message. Depends on mcl_pkg.
module mcl_match (
  input  mcl_pkg::entry_t entry_i,
  input  logic            capture_i,
  input  logic            in_range_i,
  input  mcl_pkg::msg_t   msg_i,
  output mcl_pkg::entry_t entry_o,
  output logic            hit_o
);

  mcl_pkg::entry_t eff;

  always_comb begin
    eff = entry_i;
    if (capture_i) begin
      eff.unlearned = 1'b0;
      eff.cc        = msg_i.cc;
      eff.chan      = msg_i.chan;
    end
  end

  assign entry_o = eff;

  // binary sustain switches skip entries learned on the sustain controller
  assign hit_o = in_range_i && !eff.unlearned && (eff.cc == msg_i.cc)
              && ((eff.chan == mcl_pkg::ANY_CHANNEL) || (eff.chan == msg_i.chan))
              && !((eff.cc == mcl_pkg::SUSTAIN_CC) && msg_i.binary);

endmodule

[design/midi_cc_learn_mapper.sv]
// Top level of the controller learn mapper: control, ring of mapping cells.
// Depends on mcl_pkg, mcl_cell and mcl_match.
//
// An item is taken when start is high and busy is low. An arm item (or a
// message that is not a control change) completes in the accepting cycle
// and leaves busy low. A control change starts a scan: the ring of
// LAYERS*TARGETS cells rotates one position per cycle past the head, where a
// pending learn is written and each entry is tested. Results appear on
// res_o with res_valid_o high for exactly one cycle each, in slot order, the
// final one marked by last; the receiver cannot stall them. Each hit is held
// back until the next hit or the end of the scan so that last is known.
// A control change keeps busy high while the ring steps through every position
// and then through the flush state. The last result is on the ports in the
// first cycle with busy low, in which the next item can already be taken.
// The configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
// number of active layers; it is always ready and must be written while idle.
// Reset marks every entry unlearned on any channel, clears the pending
// learn and sets the active layer count to one.
module midi_cc_learn_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mcl_pkg::in_t       data_i,
  output logic               res_valid_o,
  output mcl_pkg::out_t      res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i
);

  localparam int SW  = mcl_pkg::SLOT_W;
  localparam int LCW = mcl_pkg::LCW;

  mcl_pkg::state_e state_q, state_d;

  logic [2:0]     active_q;
  logic           armed_q, armed_d;
  logic [SW-1:0]  slot_q, slot_d;
  logic [LCW-1:0] slot_layer_q, slot_layer_d;
  logic           cap_q, cap_d;
  mcl_pkg::msg_t  msg_q, msg_d;
  logic [LCW-1:0] first_q, first_d;
  logic [LCW-1:0] stop_q, stop_d;
  logic [SW-1:0]  cnt_q, cnt_d;
  logic [LCW-1:0] lcnt_q, lcnt_d;
  logic [2:0]     tcnt_q, tcnt_d;
  logic           pend_q, pend_d;
  logic [1:0]     pend_layer_q, pend_layer_d;
  logic [2:0]     pend_target_q, pend_target_d;
  logic           res_valid_q, res_valid_d;
  mcl_pkg::out_t  res_q, res_d;

  logic           accept;
  logic           arm_ok;
  logic           binary;
  logic [LCW-1:0] in_layer;
  logic           shift;
  logic           head_cap;
  logic           in_range;
  logic           hit;

  mcl_pkg::entry_t ring [mcl_pkg::SLOTS];
  mcl_pkg::entry_t head_eff;

  assign accept      = start && !busy;
  assign busy        = (state_q != mcl_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_layer    = LCW'(data_i.layer);
  assign arm_ok      = (32'(data_i.layer) < mcl_pkg::LAYERS)
                    && (32'(data_i.target) < mcl_pkg::TARGETS);
  assign binary      = (data_i.cc_number == mcl_pkg::SUSTAIN_CC)
                    && ((data_i.cc_value == 7'd0) || (data_i.cc_value == mcl_pkg::VALUE_MAX));

  assign shift    = (state_q == mcl_pkg::ST_SCAN);
  assign head_cap = cap_q && (cnt_q == slot_q);
  assign in_range = (lcnt_q >= first_q) && (lcnt_q < stop_q);

  // ring of cells: each takes its upper neighbour, the last takes the head
  for (genvar k = 0; k < mcl_pkg::SLOTS; k++) begin : g_cell
    mcl_pkg::entry_t nb;
    if (k == mcl_pkg::SLOTS - 1) begin : g_wrap
      assign nb = head_eff;
    end else begin : g_link
      assign nb = ring[k+1];
    end
    mcl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (nb),
      .entry_o (ring[k])
    );
  end

  mcl_match u_match (
    .entry_i    (ring[0]),
    .capture_i  (head_cap),
    .in_range_i (in_range),
    .msg_i      (msg_q),
    .entry_o    (head_eff),
    .hit_o      (hit)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcl_pkg::ST_IDLE: begin
        if (accept && (data_i.opcode == mcl_pkg::OP_MIDI) && data_i.is_controller) begin
          state_d = mcl_pkg::ST_SCAN;
        end
      end
      mcl_pkg::ST_SCAN: begin
        if (cnt_q == SW'(mcl_pkg::SLOTS - 1)) begin
          state_d = mcl_pkg::ST_FLUSH;
        end
      end
      mcl_pkg::ST_FLUSH: state_d = mcl_pkg::ST_IDLE;
      default:           state_d = mcl_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    armed_d       = armed_q;
    slot_d        = slot_q;
    slot_layer_d  = slot_layer_q;
    cap_d         = cap_q;
    msg_d         = msg_q;
    first_d       = first_q;
    stop_d        = stop_q;
    cnt_d         = cnt_q;
    lcnt_d        = lcnt_q;
    tcnt_d        = tcnt_q;
    pend_d        = pend_q;
    pend_layer_d  = pend_layer_q;
    pend_target_d = pend_target_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;

    unique case (state_q)
      mcl_pkg::ST_IDLE: begin
        if (accept) begin
          if (data_i.opcode == mcl_pkg::OP_ARM) begin
            if (arm_ok) begin
              armed_d      = 1'b1;
              slot_d       = SW'(SW'(data_i.layer) * SW'(mcl_pkg::TARGETS)
                                 + SW'(data_i.target));
              slot_layer_d = in_layer;
            end
          end else if (data_i.is_controller) begin
            cap_d = armed_q && !binary
                 && (!data_i.filter_enable || (in_layer == slot_layer_q));
            if (cap_d) begin
              armed_d = 1'b0;
            end
            msg_d.cc     = data_i.cc_number;
            msg_d.chan   = data_i.channel;
            msg_d.val    = data_i.cc_value;
            msg_d.binary = binary;
            if (data_i.filter_enable) begin
              if (32'(data_i.layer) >= mcl_pkg::LAYERS) begin
                first_d = '0;
                stop_d  = '0;
              end else begin
                first_d = in_layer;
                stop_d  = in_layer + LCW'(1);
              end
            end else begin
              first_d = '0;
              stop_d  = (32'(active_q) > mcl_pkg::LAYERS) ? LCW'(mcl_pkg::LAYERS)
                                                          : LCW'(active_q);
            end
            cnt_d  = '0;
            lcnt_d = '0;
            tcnt_d = '0;
            pend_d = 1'b0;
          end
        end
      end
      mcl_pkg::ST_SCAN: begin
        // hold one hit back so the final one can be marked
        if (hit) begin
          if (pend_q) begin
            res_valid_d      = 1'b1;
            res_d.upd_layer  = pend_layer_q;
            res_d.upd_target = pend_target_q;
            res_d.upd_value  = msg_q.val;
            res_d.last       = 1'b0;
          end
          pend_d        = 1'b1;
          pend_layer_d  = lcnt_q[1:0];
          pend_target_d = tcnt_q;
        end
        cnt_d = cnt_q + SW'(1);
        if (tcnt_q == 3'(mcl_pkg::TARGETS - 1)) begin
          tcnt_d = '0;
          lcnt_d = lcnt_q + LCW'(1);
        end else begin
          tcnt_d = tcnt_q + 3'd1;
        end
      end
      mcl_pkg::ST_FLUSH: begin
        if (pend_q) begin
          res_valid_d      = 1'b1;
          res_d.upd_layer  = pend_layer_q;
          res_d.upd_target = pend_target_q;
          res_d.upd_value  = msg_q.val;
          res_d.last       = 1'b1;
        end
        pend_d = 1'b0;
        cap_d  = 1'b0;
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcl_pkg::ST_IDLE;
      active_q     <= 3'd1;
      armed_q      <= 1'b0;
      slot_q       <= '0;
      slot_layer_q <= '0;
      cap_q        <= 1'b0;
      cnt_q        <= '0;
      lcnt_q       <= '0;
      tcnt_q       <= '0;
      pend_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        active_q <= cfg_data_i;
      end
      armed_q      <= armed_d;
      slot_q       <= slot_d;
      slot_layer_q <= slot_layer_d;
      cap_q        <= cap_d;
      cnt_q        <= cnt_d;
      lcnt_q       <= lcnt_d;
      tcnt_q       <= tcnt_d;
      pend_q       <= pend_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q         <= msg_d;
    first_q       <= first_d;
    stop_q        <= stop_d;
    pend_layer_q  <= pend_layer_d;
    pend_target_q <= pend_target_d;
    res_q         <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[bench/midi_cc_learn_mapper_test.sv]
// Self-checking bench for midi_cc_learn_mapper: learn, re-arm, filter and sustain cases,
// then random traffic under several sender idling phases. Depends on mcl_pkg and the RTL.
module midi_cc_learn_mapper_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 40;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int RANDOM_ITEMS    = 104;

  typedef enum logic [1:0] {
    P_ITEM,
    P_CFG,
    P_DRAIN
  } plan_kind_e;

  typedef struct {
    plan_kind_e   kind;
    mcl_pkg::in_t msg;
    logic [2:0]   layers;
    int           gap_pct;
  } plan_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  mcl_pkg::in_t  data_i      = '0;
  logic          res_valid_o;
  mcl_pkg::out_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_data_i  = '0;

  plan_t         stimulus_plan[$];
  mcl_pkg::out_t pending_updates[$];

  // predictor state
  mcl_pkg::entry_t learned_map[mcl_pkg::SLOTS];
  logic            learn_armed;
  int              learn_slot;
  logic [2:0]      layer_count;

  int predicted_cnt = 0;
  int received_cnt  = 0;
  int idle_run      = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;

  logic [6:0] cc_pool[4] = '{7'd7, mcl_pkg::SUSTAIN_CC, 7'd1, 7'd74};

  midi_cc_learn_mapper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .data_i     (data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #HALF_PERIOD;
    clk_i = 1'b0;
    #HALF_PERIOD;
  end

  // Apply one item to the predicted table and queue the updates it causes.
  task automatic learn_and_map(input mcl_pkg::in_t m);
    logic          sustain_switch;
    int            lo;
    int            hi;
    int            s;
    int            hits[$];
    mcl_pkg::out_t u;
    if (m.opcode == mcl_pkg::OP_ARM) begin
      if (m.layer < mcl_pkg::LAYERS && m.target < mcl_pkg::TARGETS) begin
        learn_armed = 1'b1;
        learn_slot  = m.layer * mcl_pkg::TARGETS + m.target;
      end
    end else if (m.is_controller) begin
      sustain_switch = (m.cc_number == mcl_pkg::SUSTAIN_CC) &&
                       (m.cc_value == 7'd0 || m.cc_value == mcl_pkg::VALUE_MAX);
      if (learn_armed && !sustain_switch &&
          (!m.filter_enable || m.layer == learn_slot / mcl_pkg::TARGETS)) begin
        learned_map[learn_slot] = '{unlearned: 1'b0, cc: m.cc_number, chan: m.channel};
        learn_armed = 1'b0;
      end
      if (m.filter_enable) begin
        lo = m.layer;
        hi = (m.layer < mcl_pkg::LAYERS) ? m.layer + 1 : m.layer;
      end else begin
        lo = 0;
        hi = (layer_count > mcl_pkg::LAYERS) ? mcl_pkg::LAYERS : layer_count;
      end
      for (int l = lo; l < hi; l++) begin
        for (int t = 0; t < mcl_pkg::TARGETS; t++) begin
          s = l * mcl_pkg::TARGETS + t;
          if (!learned_map[s].unlearned && learned_map[s].cc == m.cc_number &&
              (learned_map[s].chan == mcl_pkg::ANY_CHANNEL ||
               learned_map[s].chan == m.channel) &&
              !(learned_map[s].cc == mcl_pkg::SUSTAIN_CC && sustain_switch))
            hits.insert(hits.size(), s);
        end
      end
      foreach (hits[i]) begin
        u.upd_layer  = 2'(hits[i] / mcl_pkg::TARGETS);
        u.upd_target = 3'(hits[i] % mcl_pkg::TARGETS);
        u.upd_value  = m.cc_value;
        u.last       = (i == hits.size() - 1);
        pending_updates.insert(pending_updates.size(), u);
      end
      predicted_cnt += hits.size();
    end
  endtask

  function automatic mcl_pkg::in_t random_bits();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(mcl_pkg::in_t)-1:0];
  endfunction

  function automatic mcl_pkg::in_t arm_msg(input int l, input int t);
    mcl_pkg::in_t m;
    m        = random_bits();
    m.opcode = mcl_pkg::OP_ARM;
    m.layer  = 3'(l);
    m.target = 3'(t);
    return m;
  endfunction

  function automatic mcl_pkg::in_t cc_msg(input int cc, input int ch, input int val,
                                          input logic filt, input int l);
    mcl_pkg::in_t m;
    m               = random_bits();
    m.opcode        = mcl_pkg::OP_MIDI;
    m.is_controller = 1'b1;
    m.cc_number     = 7'(cc);
    m.channel       = 5'(ch);
    m.cc_value      = 7'(val);
    m.filter_enable = filt;
    m.layer         = 3'(l);
    return m;
  endfunction

  // Mostly controller messages on a few popular numbers, some arms and noise.
  function automatic mcl_pkg::in_t noisy_msg();
    mcl_pkg::in_t m;
    int           pick;
    m    = random_bits();
    pick = $urandom_range(99);
    m.layer = ($urandom_range(7) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
    if (pick < 15) begin
      m.opcode = mcl_pkg::OP_ARM;
      m.target = ($urandom_range(7) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    end else begin
      m.opcode        = mcl_pkg::OP_MIDI;
      m.is_controller = (pick < 95);
      if ($urandom_range(4) != 0)
        m.cc_number = cc_pool[$urandom_range(3)];
      case ($urandom_range(5))
        0:       m.cc_value = 7'd0;
        1:       m.cc_value = mcl_pkg::VALUE_MAX;
        default: m.cc_value = 7'($urandom_range(127));
      endcase
      case ($urandom_range(9)) inside
        0:       m.channel = mcl_pkg::ANY_CHANNEL;
        1:       m.channel = 5'($urandom_range(17, 31));
        [2:3]:   m.channel = 5'($urandom_range(1, 16));
        default: m.channel = 5'($urandom_range(1, 3));
      endcase
      m.filter_enable = ($urandom_range(3) == 0);
    end
    return m;
  endfunction

  function automatic logic has_effect(input mcl_pkg::in_t m);
    if (m.opcode == mcl_pkg::OP_ARM)
      return m.layer < mcl_pkg::LAYERS && m.target < mcl_pkg::TARGETS;
    return m.is_controller;
  endfunction

  task automatic add_item(input mcl_pkg::in_t m, input int gap);
    plan_t p;
    p = '{kind: P_ITEM, msg: m, layers: '0, gap_pct: gap};
    stimulus_plan.insert(stimulus_plan.size(), p);
  endtask

  task automatic add_cfg(input int layers);
    plan_t p;
    p = '{kind: P_CFG, msg: '0, layers: 3'(layers), gap_pct: 0};
    stimulus_plan.insert(stimulus_plan.size(), p);
  endtask

  task automatic add_drain();
    plan_t p;
    p = '{kind: P_DRAIN, msg: '0, layers: '0, gap_pct: 0};
    stimulus_plan.insert(stimulus_plan.size(), p);
  endtask

  // Driver: feed the plan, one item or register write at a time.
  always @(posedge clk_i) begin : drive
    logic next_start;
    logic next_cfg;
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      idle_run     = 0;
    end else begin
      next_start = 1'b0;
      next_cfg   = 1'b0;
      if (start && !busy) begin
        learn_and_map(data_i);
        void'(stimulus_plan.pop_front());
      end else if (start) begin
        next_start = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        layer_count = cfg_data_i;
        void'(stimulus_plan.pop_front());
      end else if (cfg_valid_i) begin
        next_cfg = 1'b1;
      end
      if (busy || res_valid_o || start || cfg_valid_i || predicted_cnt != received_cnt)
        idle_run = 0;
      else if (idle_run < SETTLE_CYCLES)
        idle_run++;
      if (!next_start && !next_cfg && stimulus_plan.size() != 0) begin
        case (stimulus_plan[0].kind)
          P_ITEM: begin
            if ($urandom_range(99) >= stimulus_plan[0].gap_pct) begin
              next_start = 1'b1;
              data_i    <= stimulus_plan[0].msg;
            end
          end
          P_CFG: begin
            if (idle_run >= SETTLE_CYCLES) begin
              next_cfg    = 1'b1;
              cfg_data_i <= stimulus_plan[0].layers;
            end
          end
          default: begin
            // hold off until the block has gone quiet
            if (idle_run >= SETTLE_CYCLES)
              void'(stimulus_plan.pop_front());
          end
        endcase
      end
      start       <= next_start;
      cfg_valid_i <= next_cfg;
    end
  end

  // Monitor: check each update against the oldest prediction; watch for a hang.
  always @(posedge clk_i) begin : observe
    mcl_pkg::out_t want;
    if (rst_ni) begin
      if (res_valid_o) begin
        received_cnt <= received_cnt + 1;
        if (pending_updates.size() == 0) begin
          mismatches++;
          $display("%0t: extra update, expected none, got layer %0d target %0d value %0d last %0b",
                   $time, res_o.upd_layer, res_o.upd_target, res_o.upd_value, res_o.last);
        end else begin
          want = pending_updates.pop_front();
          if (res_o.upd_layer !== want.upd_layer || res_o.upd_target !== want.upd_target ||
              res_o.upd_value !== want.upd_value || res_o.last !== want.last) begin
            mismatches++;
            $display("%0t: update mismatch, expected layer %0d target %0d value %0d last %0b",
                     $time, want.upd_layer, want.upd_target, want.upd_value, want.last);
            $display("%0t:                  got layer %0d target %0d value %0d last %0b",
                     $time, res_o.upd_layer, res_o.upd_target, res_o.upd_value, res_o.last);
          end
        end
      end
      if (res_valid_o || (start && !busy) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : run
    int           gaps[4];
    int           layer_settings[4];
    int           useful;
    mcl_pkg::in_t m;
    mcl_pkg::in_t a;
    gaps           = '{0, 83, 0, 22};
    layer_settings = '{4, 2, 7, 1};
    foreach (learned_map[i])
      learned_map[i] = mcl_pkg::ENTRY_RESET;
    learn_armed = 1'b0;
    learn_slot  = 0;
    layer_count = 3'd1;

    // directed: ignored items, learn, re-arm, sustain switch, filter, layer count
    m = random_bits();
    m.opcode        = mcl_pkg::OP_MIDI;
    m.is_controller = 1'b0;
    m.cc_number     = 7'd7;
    add_item(m, 0);
    add_item(arm_msg(4, 0), 0);
    add_item(arm_msg(0, 7), 0);
    add_item(cc_msg(7, 1, 127, 1'b0, 0), 0);
    add_item(arm_msg(0, 0), 0);
    add_item(cc_msg(7, 1, 127, 1'b0, 0), 0);
    add_item(arm_msg(0, 1), 0);
    add_item(arm_msg(0, 2), 0);
    add_item(cc_msg(7, 0, 0, 1'b0, 0), 0);
    add_item(arm_msg(0, 3), 0);
    add_item(cc_msg(64, 2, 127, 1'b0, 0), 0);
    add_item(cc_msg(64, 2, 64, 1'b0, 0), 0);
    add_item(cc_msg(64, 2, 0, 1'b0, 0), 0);
    add_item(arm_msg(1, 4), 0);
    add_item(cc_msg(30, 1, 5, 1'b1, 0), 0);
    add_item(cc_msg(7, 1, 55, 1'b1, 1), 0);
    add_item(cc_msg(7, 1, 55, 1'b1, 6), 0);
    add_cfg(4);
    add_item(cc_msg(7, 1, 1, 1'b0, 0), 0);
    add_cfg(0);
    add_item(cc_msg(7, 1, 9, 1'b0, 0), 0);
    add_cfg(7);
    add_item(arm_msg(3, 4), 0);
    add_item(cc_msg(127, 16, 127, 1'b0, 0), 0);
    add_item(cc_msg(127, 31, 126, 1'b1, 3), 0);
    add_item(cc_msg(7, 5, 42, 1'b0, 0), 0);

    // random: learn sequences with random content, mixed with noise
    foreach (gaps[p]) begin
      add_cfg(layer_settings[p]);
      useful = 0;
      while (useful < RANDOM_ITEMS / 4) begin
        if ($urandom_range(99) < 35) begin
          a = arm_msg($urandom_range(3), $urandom_range(4));
          m = noisy_msg();
          m.opcode        = mcl_pkg::OP_MIDI;
          m.is_controller = 1'b1;
          m.cc_number     = cc_pool[$urandom_range(3)];
          if (m.filter_enable)
            m.layer = a.layer;
          add_item(a, gaps[p]);
          add_item(m, gaps[p]);
          useful += 2;
        end else begin
          m = noisy_msg();
          add_item(m, gaps[p]);
          if (has_effect(m))
            useful++;
        end
        if ($urandom_range(99) < 4)
          add_drain();
      end
      add_drain();
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stimulus_plan.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (pending_updates.size() != 0) begin
      mismatches += pending_updates.size();
      $display("%0t: %0d expected updates never arrived", $time, pending_updates.size());
    end
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
design/mcl_pkg.sv
design/mcl_cell.sv
design/mcl_match.sv
design/midi_cc_learn_mapper.sv
bench/midi_cc_learn_mapper_test.sv
